>>> hdl/dmcd_pkg.sv
// ----------------------------------------------------------------------------
// dmcd_pkg
// Shared types, constants and calendar helpers for the day/minute to
// calendar date converter.
// ----------------------------------------------------------------------------
package dmcd_pkg;

  localparam int unsigned DayW    = 15;
  localparam int unsigned MinW    = 11;
  localparam int unsigned YearW   = 12;
  localparam int unsigned YoffW   = 7;   // years past the epoch, 0 to 89
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DomW    = 5;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned HourW   = 6;
  localparam int unsigned MinuteW = 6;

  localparam logic [YearW-1:0]  EpochYear  = 12'd1980;
  localparam logic [MinW-1:0]   MinPerHour = 11'd60;
  localparam logic [3:0]        DaysPerWeek = 4'd7;
  localparam logic [8:0]        DaysCommon = 9'd365;
  localparam logic [8:0]        DaysLeap   = 9'd366;
  localparam logic [MonthW-1:0] MonthJan   = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;

  typedef struct packed {
    logic [DayW-1:0] day_count;
    logic [MinW-1:0] minute_of_day;
  } in_word_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DomW-1:0]    day_of_month;
    logic [WdayW-1:0]   weekday;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step_year;
    logic step_month;
    logic step_hour;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_fits;
    logic month_fits;
    logic hour_done;
  } status_t;

  // Length of a month in days; February follows the leap flag.
  function automatic logic [4:0] month_len(input logic [MonthW-1:0] month,
                                           input logic leap);
    logic [4:0] len;
    if (month == MonthFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

>>> hdl/dmcd_datapath.sv
// ----------------------------------------------------------------------------
// dmcd_datapath
// Working registers for the year, month and hour reductions, the weekday
// residue, and the result register with its strobe.
// ----------------------------------------------------------------------------
module dmcd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dmcd_pkg::in_word_t  request,
  input  dmcd_pkg::cmd_t      cmd,
  output dmcd_pkg::status_t   status,
  output dmcd_pkg::out_word_t result,
  output logic                done
);
  import dmcd_pkg::*;

  logic [DayW-1:0]    days;
  logic [YoffW-1:0]   yoff;
  logic [MonthW-1:0]  month;
  logic [MinW-1:0]    mins;
  logic [HourW-1:0]   hour;
  logic [WdayW-1:0]   weekday;

  logic               leap;
  logic [8:0]         year_len;
  logic [4:0]         mon_len;
  logic [WdayW-1:0]   weekday_in;

  // (n mod 7) + 1 for a 16-bit n. Since 8 mod 7 is 1, summing octal
  // digits keeps the residue; two folds and one correction finish it.
  function automatic logic [WdayW-1:0] weekday_of(input logic [DayW:0] n);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {3'd0, n[2:0]} + {3'd0, n[5:3]} + {3'd0, n[8:6]} + {3'd0, n[11:9]}
       + {3'd0, n[14:12]} + {5'd0, n[15]};
    s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
    r  = (s2 >= DaysPerWeek) ? (s2 - DaysPerWeek) : s2;
    return r[WdayW-1:0] + 3'd1;
  endfunction

  assign leap       = (yoff[1:0] == 2'b00);
  assign year_len   = leap ? DaysLeap : DaysCommon;
  assign mon_len    = month_len(month, leap);
  assign weekday_in = weekday_of({1'b0, request.day_count} + 16'd1);

  assign status.year_fits  = (days < {6'd0, year_len});
  assign status.month_fits = (month == MonthDec) || (days < {10'd0, mon_len});
  assign status.hour_done  = (mins < MinPerHour);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      days    <= request.day_count;
      mins    <= request.minute_of_day;
      yoff    <= '0;
      month   <= MonthJan;
      hour    <= '0;
      weekday <= weekday_in;
    end else begin
      if (cmd.step_year) begin
        days <= days - {6'd0, year_len};
        yoff <= yoff + 7'd1;
      end
      if (cmd.step_month) begin
        days  <= days - {10'd0, mon_len};
        month <= month + 4'd1;
      end
      if (cmd.step_hour) begin
        mins <= mins - MinPerHour;
        hour <= hour + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.year         <= EpochYear + {5'd0, yoff};
      result.month        <= month;
      result.day_of_month <= days[DomW-1:0] + 5'd1;
      result.weekday      <= weekday;
      result.hour         <= hour;
      result.minute       <= mins[MinuteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.publish;
    end
  end

  // A month is stepped only after the year search has settled.
  a_month_after_year: assert property (@(posedge clk) disable iff (rst)
    cmd.step_month |-> status.year_fits)
    else $error("month step while a whole year still remains");

  // The month counter never passes December.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step_month |-> (month != MonthDec))
    else $error("month step beyond December");

  // A published word always carries a reduced minute.
  a_publish_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (status.hour_done && status.month_fits))
    else $error("result published before reduction finished");

endmodule

>>> hdl/dmcd_controller.sv
// ----------------------------------------------------------------------------
// dmcd_controller
// Sequencer for the year, month and hour subtraction loops.
// ----------------------------------------------------------------------------
module dmcd_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dmcd_pkg::status_t status,
  output dmcd_pkg::cmd_t    cmd,
  output logic              busy
);
  import dmcd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_YEARS;
      end
      ST_YEARS: begin
        if (status.year_fits) state_next = ST_MONTHS;
      end
      ST_MONTHS: begin
        if (status.month_fits && status.hour_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_YEARS: begin
        cmd.step_year = !status.year_fits;
        cmd.step_hour = !status.hour_done;
      end
      ST_MONTHS: begin
        cmd.step_month = !status.month_fits;
        cmd.step_hour  = !status.hour_done;
        cmd.publish    = status.month_fits && status.hour_done;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/days_minutes_to_calendar_date.sv
// ----------------------------------------------------------------------------
// days_minutes_to_calendar_date
// Converts a day count since 1 January 1980 and a minute count since
// midnight into year, month, day of month, weekday, hour and minute.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low. The block then works on that one word and drops busy at the edge
// where the result word appears; done is high for exactly that one cycle and
// the result must be captured then, since the receiver cannot stall the
// block. The result ports keep their value until the next result is written.
// From the accepting edge the block subtracts whole years past 1980 (up to
// 89), then whole months (up to 11, the month index minus one), and then
// writes the result word. The last day the count can reach falls in
// September 2069, so the longest conversion is for a date in December 2068.
// The hour is found by subtracting 60 once a cycle alongside the year and
// month loops, so it lengthens the conversion only when the hour is large
// and the date early; the year subtraction loop sets the worst case. The
// weekday is ((day_count + 1) mod 7) + 1, so day 0, a Tuesday, gives 2;
// minutes are not clamped, so the hour can reach 34 and the date does not
// advance.
// ----------------------------------------------------------------------------
module days_minutes_to_calendar_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dmcd_pkg::in_word_t  request,
  output logic                done,
  output dmcd_pkg::out_word_t result
);
  import dmcd_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  // The controller owns the handshake and the loop sequencing.
  dmcd_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the working registers and the result register.
  dmcd_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

  // An accepted word always makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A result only appears as the block returns to idle, and is in range.
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && (result.month >= 4'd1) && (result.month <= 4'd12)
              && (result.minute < 6'd60)))
    else $error("result word out of range or block still busy");

endmodule
